@@ design/wsdb_pkg.sv @@
// wsdb_pkg: sizes, codes, generator seeds and link types of the deque bank
// depends on nothing; imported by wsdb_victim_gen and work_stealing_deque_bank
`default_nettype none

package wsdb_pkg;

   localparam int QUEUE_DEPTH = 256;
   localparam int NUM_QUEUES  = 8;

   localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
   localparam int POS_W    = SLOT_W + 1;
   localparam int QUEUE_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int ADDR_W   = QUEUE_W + SLOT_W;
   localparam int HANDLE_W = 8;
   localparam int WORKER_W = 3;
   localparam int NW_W     = 4;
   localparam int RNG_W    = 32;

   localparam int MOD_DIGIT = 4;
   localparam int MOD_STEPS = RNG_W / MOD_DIGIT;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);

   localparam logic [RNG_W-1:0] RNG_X_SEED = 32'd123456789;
   localparam logic [RNG_W-1:0] RNG_Y_SEED = 32'd362436069;
   localparam logic [RNG_W-1:0] RNG_Z_SEED = 32'd521288629;
   localparam int RNG_SHL_A = 16;
   localparam int RNG_SHR_B = 5;
   localparam int RNG_SHL_C = 1;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_GET  = 1'b1;

   localparam logic [NW_W-1:0] NUM_WORKERS_RESET = 4'd1;

   typedef struct packed {
      logic            start;
      logic [NW_W-1:0] divisor;
   } victim_req_type;

   typedef struct packed {
      logic            done;
      logic [NW_W-1:0] victim;
   } victim_rsp_type;

endpackage

`default_nettype wire

@@ design/wsdb_slot_ram.sv @@
// wsdb_slot_ram: simple dual-port ram, one write and one registered read port
// generic; no package dependency
`default_nettype none

module wsdb_slot_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 11
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ design/wsdb_victim_gen.sv @@
// wsdb_victim_gen: xorshift96 generator and iterative modulo for victim choice
// depends on wsdb_pkg
`default_nettype none

module wsdb_victim_gen
   import wsdb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire victim_req_type ctl,
   output victim_rsp_type      sts
);

   logic [RNG_W-1:0]     rng_x_ff, rng_x_in;
   logic [RNG_W-1:0]     rng_y_ff, rng_y_in;
   logic [RNG_W-1:0]     rng_z_ff, rng_z_in;
   logic [RNG_W-1:0]     rng_t;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RNG_W-1:0]     dvd_ff, dvd_in;
   logic [NW_W-1:0]      rem_ff, rem_in;
   logic [NW_W-1:0]      div_ff, div_in;
   logic [NW_W:0]        part;

   always_comb begin
      rng_t = rng_x_ff ^ (rng_x_ff << RNG_SHL_A);
      rng_t = rng_t ^ (rng_t >> RNG_SHR_B);
      rng_t = rng_t ^ (rng_t << RNG_SHL_C);
   end

   // four quotient bits per cycle, restoring remainder
   always_comb begin
      part = {1'b0, rem_ff};
      for (int i = 0; i < MOD_DIGIT; i++) begin
         part = {part[NW_W-1:0], dvd_ff[RNG_W-1-i]};
         if (part >= {1'b0, div_ff}) begin
            part = part - {1'b0, div_ff};
         end
      end
   end

   always_comb begin
      rng_x_in = rng_x_ff;
      rng_y_in = rng_y_ff;
      rng_z_in = rng_z_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (ctl.start && !busy_ff) begin
         rng_x_in = rng_y_ff;
         rng_y_in = rng_z_ff;
         rng_z_in = rng_t ^ rng_y_ff ^ rng_z_ff;
         dvd_in   = rng_t ^ rng_y_ff ^ rng_z_ff;
         rem_in   = '0;
         cnt_in   = '0;
         div_in   = (ctl.divisor == '0) ? NW_W'(1) : ctl.divisor;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in = part[NW_W-1:0];
         dvd_in = dvd_ff << MOD_DIGIT;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_x_ff <= RNG_X_SEED;
         rng_y_ff <= RNG_Y_SEED;
         rng_z_ff <= RNG_Z_SEED;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         rng_x_ff <= rng_x_in;
         rng_y_ff <= rng_y_in;
         rng_z_ff <= rng_z_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign sts.done   = done_ff;
   assign sts.victim = rem_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (rem_ff < div_ff))
      else $error("victim not below divisor");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (div_ff != '0))
      else $error("zero divisor in modulo unit");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("done without a finished modulo run");

endmodule

`default_nettype wire

@@ design/work_stealing_deque_bank.sv @@
// work_stealing_deque_bank: top level, request sequencer, index tables, result register
// depends on wsdb_pkg, wsdb_slot_ram, wsdb_victim_gen
//
// usage:
//   req channel carries one transaction per request: req_tuser is the action
//   (0 push, 1 get), req_tdata holds worker and job handle. rsp channel returns
//   exactly one transaction per request, in order: rsp_tdata is the handle,
//   rsp_tuser the found, stolen and overflow flags. csr_wen writes num_workers;
//   the user must do so only while the block is idle; the block does not enforce it.
// path from acceptance to rsp_tvalid: a push goes through exec and resp, an own pop
//   through exec, pop and resp, a get that falls through to a steal through exec,
//   mod, vict, steal and resp. requests are taken one at a time and the block
//   accepts again in the cycle after the result is loaded. the steal path is set
//   by the modulo unit (four bits of the 32-bit generator word per cycle, then a
//   done flag) plus one slot ram read.
// a finished result waits in the output register while the next request is
//   taken; while rsp_tvalid waits on rsp_tready the sequencer holds in its last step.
// reset clears all top and bottom indices, seeds the generator, sets
//   num_workers to 1. slot ram contents are not cleared and need no sweep.
`default_nettype none

module work_stealing_deque_bank
   import wsdb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // worker [2:0], job_handle [10:3], zeros
   input  wire logic        req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // job_out [7:0]
   output logic [2:0]       rsp_tuser,   // found [0], stolen [1], overflow [2]
   input  wire logic        csr_wen,
   input  wire logic [3:0]  csr_wdata    // num_workers
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EXEC  = 7'b0000010,
      S_POP   = 7'b0000100,
      S_MOD   = 7'b0001000,
      S_VICT  = 7'b0010000,
      S_STEAL = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic                req_action_ff;
   logic [WORKER_W-1:0] req_worker_ff;
   logic [HANDLE_W-1:0] req_handle_ff;
   logic [NW_W-1:0]     num_workers_ff;

   logic [POS_W-1:0] top_ff    [NUM_QUEUES];
   logic [POS_W-1:0] bottom_ff [NUM_QUEUES];
   logic [POS_W-1:0] top_in, bottom_in;
   logic             idx_wr;
   logic             top_wr;
   logic [QUEUE_W-1:0] idx_q;

   logic [HANDLE_W-1:0] res_job_ff, res_job_in;
   logic                res_found_ff, res_found_in;
   logic                res_stolen_ff, res_stolen_in;
   logic                res_ovf_ff, res_ovf_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_data_ff;
   logic [2:0]          rsp_user_ff;
   logic                rsp_load;

   logic [NW_W-1:0]  victim_ff;
   logic [POS_W-1:0] cur_top, cur_bot, cur_fill, bot_dec;
   logic             worker_ok, victim_ok;

   logic                ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [HANDLE_W-1:0] ram_rd_data;

   victim_req_type vg_ctl;
   victim_rsp_type vg_sts;

   wsdb_slot_ram #(
      .DATA_W (HANDLE_W),
      .ADDR_W (ADDR_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_handle_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   wsdb_victim_gen u_victim_gen (
      .clock (clock),
      .reset (reset),
      .ctl   (vg_ctl),
      .sts   (vg_sts)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // one index-table read port: own queue, or the victim once it is known
   assign idx_q    = (state_ff == S_VICT) ? QUEUE_W'(victim_ff) : QUEUE_W'(req_worker_ff);
   assign cur_top  = top_ff[idx_q];
   assign cur_bot  = bottom_ff[idx_q];
   assign cur_fill = cur_bot - cur_top;
   assign bot_dec  = cur_bot - 1'b1;

   assign worker_ok = int'(req_worker_ff) < NUM_QUEUES;
   assign victim_ok = (int'(victim_ff) < NUM_QUEUES)
                   && ({1'b0, req_worker_ff} != victim_ff);

   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      res_job_in     = res_job_ff;
      res_found_in   = res_found_ff;
      res_stolen_in  = res_stolen_ff;
      res_ovf_in     = res_ovf_ff;
      idx_wr         = 1'b0;
      top_wr         = 1'b0;
      top_in         = cur_top;
      bottom_in      = cur_bot;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = {idx_q, cur_bot[SLOT_W-1:0]};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = {idx_q, bot_dec[SLOT_W-1:0]};
      vg_ctl.start   = 1'b0;
      vg_ctl.divisor = num_workers_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_job_in    = '0;
            res_found_in  = 1'b0;
            res_stolen_in = 1'b0;
            res_ovf_in    = 1'b0;
            state_in      = S_RESP;
            if (!worker_ok) begin
               state_in = S_RESP;
            end else if (req_action_ff == ACTION_PUSH) begin
               if (cur_fill[POS_W-1]) begin
                  res_ovf_in = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  bottom_in = cur_bot + 1'b1;
                  idx_wr    = 1'b1;
               end
            end else if (cur_fill != '0) begin
               ram_rd_en = 1'b1;
               idx_wr    = 1'b1;
               if (cur_fill == POS_W'(1)) begin
                  top_in    = cur_top + 1'b1;
                  bottom_in = cur_top + 1'b1;
               end else begin
                  bottom_in = bot_dec;
               end
               state_in = S_POP;
            end else begin
               vg_ctl.start = 1'b1;
               state_in     = S_MOD;
            end
         end
         S_POP: begin
            res_job_in   = ram_rd_data;
            res_found_in = 1'b1;
            state_in     = S_RESP;
         end
         S_MOD: begin
            if (vg_sts.done) begin
               state_in = S_VICT;
            end
         end
         S_VICT: begin
            ram_rd_addr = {idx_q, cur_top[SLOT_W-1:0]};
            if (victim_ok && cur_fill != '0) begin
               ram_rd_en = 1'b1;
               top_in    = cur_top + 1'b1;
               top_wr    = 1'b1;
               state_in  = S_STEAL;
            end else begin
               state_in = S_RESP;
            end
         end
         S_STEAL: begin
            res_job_in    = ram_rd_data;
            res_found_in  = 1'b1;
            res_stolen_in = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         num_workers_ff <= NUM_WORKERS_RESET;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            top_ff[q]    <= '0;
            bottom_ff[q] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            num_workers_ff <= csr_wdata;
         end
         if (idx_wr) begin
            top_ff[idx_q]    <= top_in;
            bottom_ff[idx_q] <= bottom_in;
         end else if (top_wr) begin
            top_ff[idx_q] <= top_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_action_ff <= req_tuser;
         req_worker_ff <= req_tdata[WORKER_W-1:0];
         req_handle_ff <= req_tdata[WORKER_W +: HANDLE_W];
      end
      if (vg_sts.done) begin
         victim_ff <= vg_sts.victim;
      end
      res_job_ff    <= res_job_in;
      res_found_ff  <= res_found_in;
      res_stolen_ff <= res_stolen_in;
      res_ovf_ff    <= res_ovf_in;
      if (rsp_load) begin
         rsp_data_ff <= res_job_ff;
         rsp_user_ff <= {res_ovf_ff, res_stolen_ff, res_found_ff};
      end
   end

   a_ram_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("slot ram read and write in the same cycle");

   a_stolen_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[1] && !rsp_user_ff[0]))
      else $error("stolen transaction without a handle");

   a_ovf_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[2] && rsp_user_ff[0]))
      else $error("overflow together with a returned handle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> (int'(cur_fill) <= QUEUE_DEPTH))
      else $error("deque fill beyond depth");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted request not executed");

endmodule

`default_nettype wire
